/* hdl/lru_writeback_node_cache_assert.svh */
// assertion macros shared by the cache modules
`ifndef LRU_WRITEBACK_NODE_CACHE_ASSERT_SVH
`define LRU_WRITEBACK_NODE_CACHE_ASSERT_SVH

// implication check, disabled during reset
`define LWNC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication check, disabled during reset
`define LWNC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/lwnc_pkg.sv */
//------------------------------------------------------------------------------
// lwnc_pkg
// shared types and constants of the node cache
//------------------------------------------------------------------------------
`default_nettype none
package lwnc_pkg;
    localparam int ENTRIES      = 8;
    localparam int RECORD_WIDTH = 64;
    localparam int IDX_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W        = $clog2(ENTRIES + 1);

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_GET   = 2'd1;
    localparam logic [1:0] MODE_SAVE  = 2'd2;
    localparam logic [1:0] MODE_FILL  = 2'd3;

    localparam logic [2:0] KIND_READ  = 3'd0;
    localparam logic [2:0] KIND_WB    = 3'd1;
    localparam logic [2:0] KIND_FREQ  = 3'd2;
    localparam logic [2:0] KIND_DONE  = 3'd3;
    localparam logic [2:0] KIND_ERR   = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] node_id;
        logic [63:0] write_data;
    } t_req;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] result_id;
        logic [63:0] result_data;
        logic        last;
    } t_rsp;
endpackage
`default_nettype wire

/* hdl/lwnc_if.sv */
//------------------------------------------------------------------------------
// lwnc_req_if / lwnc_rsp_if
// valid/ready channels carrying requests and results
//------------------------------------------------------------------------------
`default_nettype none
interface lwnc_req_if;
    logic             valid;
    logic             ready;
    lwnc_pkg::t_req   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lwnc_rsp_if;
    logic             valid;
    logic             ready;
    lwnc_pkg::t_rsp   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* hdl/lru_writeback_node_cache.sv */
//------------------------------------------------------------------------------
// lru_writeback_node_cache
// fully associative write-back node cache with timestamp lru replacement
//------------------------------------------------------------------------------
// usage:
//   i_req carries one request transaction (mode, node_id, write_data); o_rsp
//   carries one or two result transactions, the final one flagged by last.
//   allocate and fill go from acceptance to the action state, which pushes
//   their single result. get and save scan the stamp and line memories one
//   entry per cycle, set by their single read port, then act: a save hit or
//   an error pushes its result from the action state; a get hit pushes the
//   entry read for it from the read state, and a miss pushes the write-back
//   of a dirty victim there and its last result after that.
//   one request is worked on at a time; the next is taken once its results
//   have left the two-entry output buffer.
//   reset clears the valid, dirty and stamp state (valid and dirty are flops,
//   stamps read as zero until first written via per-entry written bits), the
//   id and use counters and any pending fill. no clearing pass is needed.
//   a stalled receiver holds results in the output buffer; no new request
//   is accepted until the buffer is empty.
//------------------------------------------------------------------------------
`default_nettype none
module lru_writeback_node_cache (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lwnc_req_if.sink   i_req,
    lwnc_rsp_if.source o_rsp
);
    import lwnc_pkg::*;
    `include "lru_writeback_node_cache_assert.svh"

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_LAST  = 5'b00100,
        S_ACT   = 5'b01000,
        S_RD    = 5'b10000
    } t_state;

    t_state r_state;
    t_req   r_req;

    logic [RECORD_WIDTH+31:0] mem_line  [ENTRIES];
    logic [31:0]              mem_stamp [ENTRIES];
    logic [ENTRIES-1:0]       r_valid, r_dirty, r_stamp_ok;

    logic [31:0]             r_rtag, r_rstamp;
    logic [RECORD_WIDTH-1:0] r_rrec;
    logic [IDX_W-1:0]        r_ridx;
    logic [CNT_W-1:0]        r_cnt;

    logic [31:0]  r_use, r_alloc;
    logic         r_fwait;
    logic [IDX_W-1:0] r_fslot;
    logic [31:0]  r_fid;

    logic             r_hit;
    logic [IDX_W-1:0] r_hidx, r_vidx;
    logic [31:0]      r_vstamp;
    logic             r_vfirst;

    logic [IDX_W-1:0] w_waddr;
    logic             w_we_line, w_we_stamp;
    logic [31:0]      w_wtag;
    logic [RECORD_WIDTH-1:0] w_wrec;
    logic [IDX_W-1:0] w_raddr;

    logic  w_push;
    t_rsp  w_out;
    logic  w_empty;

    logic [31:0] w_stamp_eff;
    logic [RECORD_WIDTH-1:0] w_in_rec;

    logic r_miss_tail;
    t_rsp w_fin;

    assign i_req.ready = (r_state == S_IDLE) && w_empty && !r_miss_tail;
    assign w_in_rec    = r_req.write_data[RECORD_WIDTH-1:0];
    assign w_stamp_eff = r_stamp_ok[r_ridx] ? r_rstamp : 32'd0;

    // memory read port
    always_ff @(posedge i_clk) begin
        {r_rtag, r_rrec} <= mem_line[w_raddr];
        r_rstamp         <= mem_stamp[w_raddr];
        r_ridx           <= w_raddr;
    end

    // memory write port
    always_ff @(posedge i_clk) begin
        if (w_we_line)  mem_line[w_waddr]  <= {w_wtag, w_wrec};
        if (w_we_stamp) mem_stamp[w_waddr] <= r_use;
    end

    always_comb begin
        w_raddr    = r_cnt[IDX_W-1:0];
        w_we_line  = 1'b0;
        w_we_stamp = 1'b0;
        w_waddr    = r_vidx;
        w_wtag     = r_req.node_id;
        w_wrec     = w_in_rec;
        w_push     = 1'b0;
        w_out      = '0;
        case (r_state)
            S_IDLE: begin
                w_raddr = '0;
            end
            S_ACT: begin
                if (r_req.mode == MODE_ALLOC) begin
                    w_push = 1'b1;
                    w_out  = '{KIND_DONE, r_alloc, 64'd0, 1'b1};
                end else if (r_req.mode == MODE_FILL) begin
                    w_push = 1'b1;
                    if (!r_fwait) begin
                        w_out = '{KIND_ERR, 32'd0, 64'd0, 1'b1};
                    end else begin
                        w_we_line = 1'b1;
                        w_waddr   = r_fslot;
                        w_wtag    = r_fid;
                        w_out     = '{KIND_READ, r_fid, 64'(w_in_rec), 1'b1};
                    end
                end else if (r_req.node_id >= r_alloc) begin
                    w_push = 1'b1;
                    w_out  = '{KIND_ERR, r_req.node_id, 64'd0, 1'b1};
                end else if (r_hit) begin
                    w_we_stamp = 1'b1;
                    w_waddr    = r_hidx;
                    if (r_req.mode == MODE_GET) begin
                        w_raddr = r_hidx;
                    end else begin
                        w_we_line = 1'b1;
                        w_push    = 1'b1;
                        w_out     = '{KIND_DONE, r_req.node_id, 64'd0, 1'b1};
                    end
                end else begin
                    w_raddr = r_vidx;
                end
            end
            S_RD: begin
                // r_rrec / r_rtag hold hit entry or victim
                if (r_hit) begin
                    w_push = 1'b1;
                    w_out  = '{KIND_READ, r_req.node_id, 64'(r_rrec), 1'b1};
                end else begin
                    w_push     = 1'b1;
                    w_we_stamp = 1'b1;
                    if (r_valid[r_vidx] && r_dirty[r_vidx]) begin
                        w_out = '{KIND_WB, r_rtag, 64'(r_rrec), 1'b0};
                    end else begin
                        w_push = 1'b0;
                    end
                    if (r_req.mode == MODE_SAVE) begin
                        w_we_line = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // second result of a miss is pushed into the output buffer the cycle after S_RD
    always_comb begin
        w_fin = w_out;
        if (r_miss_tail) begin
            w_fin = (r_req.mode == MODE_SAVE)
                  ? t_rsp'{KIND_DONE, r_req.node_id, 64'd0, 1'b1}
                  : t_rsp'{KIND_FREQ, r_req.node_id, 64'd0, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_dirty     <= '0;
            r_stamp_ok  <= '0;
            r_use       <= '0;
            r_alloc     <= '0;
            r_fwait     <= 1'b0;
            r_cnt       <= '0;
            r_miss_tail <= 1'b0;
        end else begin
            r_miss_tail <= 1'b0;
            if (w_we_stamp) begin
                r_stamp_ok[w_waddr] <= 1'b1;
                r_use <= r_use + 32'd1;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_req    <= i_req.payload;
                        r_hit    <= 1'b0;
                        r_vfirst <= 1'b1;
                        r_cnt    <= CNT_W'(1);
                        if (i_req.payload.mode == MODE_ALLOC ||
                            i_req.payload.mode == MODE_FILL) begin
                            r_state <= S_ACT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN, S_LAST: begin
                    if (r_valid[r_ridx] && (r_rtag == r_req.node_id) && !r_hit) begin
                        r_hit  <= 1'b1;
                        r_hidx <= r_ridx;
                    end
                    if (r_vfirst || (w_stamp_eff < r_vstamp)) begin
                        r_vidx   <= r_ridx;
                        r_vstamp <= w_stamp_eff;
                    end
                    r_vfirst <= 1'b0;
                    if (r_cnt == CNT_W'(ENTRIES)) begin
                        r_state <= S_ACT;
                    end else begin
                        r_cnt   <= r_cnt + CNT_W'(1);
                        r_state <= (r_cnt == CNT_W'(ENTRIES - 1)) ? S_LAST : S_SCAN;
                    end
                end
                S_ACT: begin
                    r_state <= S_IDLE;
                    if (r_req.mode == MODE_ALLOC) begin
                        r_alloc <= r_alloc + 32'd1;
                    end else if (r_req.mode == MODE_FILL) begin
                        if (r_fwait) begin
                            r_valid[r_fslot] <= 1'b1;
                            r_dirty[r_fslot] <= 1'b0;
                            r_fwait          <= 1'b0;
                        end
                    end else begin
                        r_fwait <= 1'b0;
                        if (r_req.node_id < r_alloc) begin
                            if (r_hit) begin
                                if (r_req.mode == MODE_GET) r_state <= S_RD;
                                else r_dirty[r_hidx] <= 1'b1;
                            end else begin
                                r_state <= S_RD;
                            end
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_IDLE;
                    if (!r_hit) begin
                        r_miss_tail <= 1'b1;
                        if (r_req.mode == MODE_SAVE) begin
                            r_valid[r_vidx] <= 1'b1;
                            r_dirty[r_vidx] <= 1'b1;
                        end else begin
                            r_valid[r_vidx] <= 1'b0;
                            r_dirty[r_vidx] <= 1'b0;
                            r_fwait <= 1'b1;
                            r_fslot <= r_vidx;
                            r_fid   <= r_req.node_id;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    lwnc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push | r_miss_tail),
        .i_data  (w_fin),
        .o_empty (w_empty),
        .o_rsp   (o_rsp)
    );

    `LWNC_ASSERT_IMP(a_idle_on_accept, i_clk, i_rst_n, i_req.valid && i_req.ready, r_state == S_IDLE)
    `LWNC_ASSERT_NEXT(a_miss_tail_after_rd, i_clk, i_rst_n, (r_state == S_RD) && !r_hit, r_miss_tail)
    `LWNC_ASSERT_IMP(a_no_double_push, i_clk, i_rst_n, r_miss_tail, !w_push)
    `LWNC_ASSERT_IMP(a_busy_no_ready, i_clk, i_rst_n, r_state != S_IDLE, !i_req.ready)
endmodule
`default_nettype wire

/* hdl/lwnc_out_buf.sv */
//------------------------------------------------------------------------------
// lwnc_out_buf
// two-entry result queue between the engine and the result channel
//------------------------------------------------------------------------------
`default_nettype none
module lwnc_out_buf (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire lwnc_pkg::t_rsp i_data,
    output logic                o_empty,
    lwnc_rsp_if.source          o_rsp
);
    import lwnc_pkg::*;
    `include "lru_writeback_node_cache_assert.svh"

    t_rsp       r_q [2];
    logic       r_rd;
    logic       r_wr;
    logic [1:0] r_cnt;
    logic       w_pop;

    assign w_pop         = o_rsp.valid && o_rsp.ready;
    assign o_rsp.valid   = (r_cnt != 2'd0);
    assign o_rsp.payload = r_q[r_rd];
    assign o_empty       = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wr] <= i_data;
    end

    `LWNC_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, (r_cnt != 2'd2) || w_pop)
    `LWNC_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3)
    `LWNC_ASSERT_NEXT(a_push_visible, i_clk, i_rst_n, i_push && (r_cnt == 2'd0), o_rsp.valid)
endmodule
`default_nettype wire
